[rtl/ssmc_pkg.sv]
// ----------------------------------------------------------------------------
// ssmc_pkg - shared types and constants of the subarray sum match counter
// widths of the prefix, count and frequency memory, pipeline item types
// ----------------------------------------------------------------------------
`default_nettype none

package ssmc_pkg;

  localparam int unsigned MAX_LENGTH    = 256;
  localparam int unsigned ELEMENT_BITS  = 8;
  localparam int unsigned ELEM_CNT_BITS = $clog2(MAX_LENGTH + 1);

  localparam int unsigned PREFIX_BITS = 16;
  localparam int unsigned COUNT_BITS  = 16;
  localparam int unsigned TARGET_BITS = 17;
  localparam int unsigned FREQ_BITS   = 9;
  localparam int unsigned EPOCH_BITS  = 8;
  localparam int unsigned MEM_DEPTH   = 1 << PREFIX_BITS;

  localparam logic [FREQ_BITS-1:0]  FREQ_MAX  = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [EPOCH_BITS-1:0] EPOCH_MAX = '1;
  // tag zero marks swept entries, arrays use tags one and up
  localparam logic [EPOCH_BITS-1:0] EPOCH_FIRST = EPOCH_BITS'(1);

  localparam int unsigned APB_ADDR_BITS = 3;
  localparam int unsigned APB_DATA_BITS = 32;

  typedef enum logic [0:0] {
    REG_TARGET_SUM = 1'b0,
    REG_UNUSED     = 1'b1
  } reg_idx_e;

  // one word of the frequency memory
  typedef struct packed {
    logic [EPOCH_BITS-1:0] tag;
    logic [FREQ_BITS-1:0]  freq;
  } mem_word_t;

  // element in flight between memory read and write-back
  typedef struct packed {
    logic                   last;
    logic                   skip;
    logic                   ovf;
    logic                   d_ok;
    logic                   eq;
    logic [PREFIX_BITS-1:0] d_addr;
    logic [PREFIX_BITS-1:0] s_addr;
    logic [EPOCH_BITS-1:0]  epoch;
  } s1_t;

  // finished result
  typedef struct packed {
    logic [COUNT_BITS-1:0] match_total;
    logic                  done;
    logic                  ovf;
  } res_t;

endpackage

`default_nettype wire

[rtl/subarray_sum_match_counter.sv]
// ----------------------------------------------------------------------------
// subarray_sum_match_counter - counts subarrays whose sum equals a target
// streams signed elements, keeps a prefix sum and a prefix frequency memory
// ----------------------------------------------------------------------------
// result path: stage one register, then output register (or skid when held)
// throughput: one request per cycle unless the sweep or a held skid stalls it;
//   memory read is registered, write-back comes from stage one
// reset: target cleared, then a clearing sweep over all 65536 frequency memory
//   entries during which no request is taken
// the same sweep follows every 255th closed array (tag wrap)
// configuration writes are taken at all times
// ----------------------------------------------------------------------------
`default_nettype none

module subarray_sum_match_counter
  import ssmc_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // request channel
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic [ELEMENT_BITS-1:0]  element_value_i,
  input  wire logic                     is_last_i,
  // result channel
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic [COUNT_BITS-1:0]         match_total_o,
  output logic                          array_done_o,
  output logic                          length_overflow_o,
  // register port
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [APB_ADDR_BITS-1:0] paddr,
  input  wire logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0]      prdata,
  output logic                          pready
);

  // --------------------------------------------------------------------------
  // register port
  // --------------------------------------------------------------------------
  logic signed [TARGET_BITS-1:0] target_q;
  reg_idx_e                      reg_idx;
  logic                          cfg_wr;

  assign reg_idx = reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
    end else if (cfg_wr && (reg_idx == REG_TARGET_SUM)) begin
      target_q <= pwdata[TARGET_BITS-1:0];
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TARGET_SUM: prdata = APB_DATA_BITS'(target_q);
      default:        prdata = '0;
    endcase
    if (reg_idx == REG_TARGET_SUM) begin
      prdata = {{(APB_DATA_BITS-TARGET_BITS){target_q[TARGET_BITS-1]}}, target_q};
    end
  end

  // --------------------------------------------------------------------------
  // handshake and pipeline enable
  // --------------------------------------------------------------------------
  logic sweep_active_q;
  logic skid_valid_q;
  logic advance;     // stage one may hand its item on
  logic in_accept;

  // the skid register absorbs one result, so stall never depends on out_stall_i
  assign advance    = !skid_valid_q;
  assign in_stall_o = !advance || sweep_active_q;
  assign in_accept  = in_valid_i && !in_stall_o;

  // --------------------------------------------------------------------------
  // stage zero: prefix sum, difference and memory addresses
  // --------------------------------------------------------------------------
  logic [PREFIX_BITS-1:0]        prefix_q;
  logic [ELEM_CNT_BITS-1:0]      elements_q;
  logic                          overflow_q;
  logic [EPOCH_BITS-1:0]         epoch_q;
  logic [PREFIX_BITS-1:0]        sweep_addr_q;

  logic [PREFIX_BITS-1:0]        elem_ext;
  logic [PREFIX_BITS-1:0]        sum;
  logic signed [TARGET_BITS-1:0] sum_ext;
  logic [TARGET_BITS:0]          diff;
  logic                          skip;
  s1_t                           s0_item;

  assign elem_ext = {{(PREFIX_BITS-ELEMENT_BITS){element_value_i[ELEMENT_BITS-1]}},
                     element_value_i};
  assign sum      = prefix_q + elem_ext;
  assign sum_ext  = {sum[PREFIX_BITS-1], sum};
  assign diff     = {sum_ext[TARGET_BITS-1], sum_ext} - {target_q[TARGET_BITS-1], target_q};
  assign skip     = elements_q >= ELEM_CNT_BITS'(MAX_LENGTH);

  always_comb begin
    s0_item.last   = is_last_i;
    s0_item.skip   = skip;
    s0_item.ovf    = overflow_q || skip;
    // difference fits the prefix range only if the top three bits agree
    s0_item.d_ok   = (diff[TARGET_BITS] == diff[PREFIX_BITS-1])
                  && (diff[TARGET_BITS-1] == diff[PREFIX_BITS-1]);
    s0_item.eq     = (sum_ext == target_q);
    s0_item.d_addr = diff[PREFIX_BITS-1:0];
    s0_item.s_addr = sum;
    s0_item.epoch  = epoch_q;
  end

  // per array state, cleared when the last element is accepted
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q   <= '0;
      elements_q <= '0;
      overflow_q <= 1'b0;
    end else if (in_accept) begin
      if (is_last_i) begin
        prefix_q   <= '0;
        elements_q <= '0;
        overflow_q <= 1'b0;
      end else if (skip) begin
        overflow_q <= 1'b1;
      end else begin
        prefix_q   <= sum;
        elements_q <= elements_q + 1'b1;
      end
    end
  end

  // array tag and clearing sweep: an entry counts only under the current tag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      epoch_q        <= EPOCH_FIRST;
      sweep_active_q <= 1'b1;
      sweep_addr_q   <= '0;
    end else begin
      if (sweep_active_q) begin
        sweep_addr_q <= sweep_addr_q + 1'b1;
        if (sweep_addr_q == PREFIX_BITS'(MEM_DEPTH - 1)) begin
          sweep_active_q <= 1'b0;
        end
      end
      if (in_accept && is_last_i) begin
        if (epoch_q == EPOCH_MAX) begin
          // tags are about to repeat, so wipe the old ones first
          epoch_q        <= EPOCH_FIRST;
          sweep_active_q <= 1'b1;
          sweep_addr_q   <= '0;
        end else begin
          epoch_q <= epoch_q + 1'b1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // frequency memory: two read ports, one write port, registered read
  // --------------------------------------------------------------------------
  mem_word_t              freq_mem [MEM_DEPTH];
  mem_word_t              rd_d_q;
  mem_word_t              rd_s_q;
  logic                   wr_en;
  logic [PREFIX_BITS-1:0] wr_addr;
  mem_word_t              wr_word;

  always_ff @(posedge clk_i) begin
    if (sweep_active_q) begin
      freq_mem[sweep_addr_q] <= '0;
    end else if (wr_en) begin
      freq_mem[wr_addr] <= wr_word;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      rd_d_q <= freq_mem[s0_item.d_addr];
      rd_s_q <= freq_mem[s0_item.s_addr];
    end
  end

  // --------------------------------------------------------------------------
  // stage one: lookup with forwarding, count update, write-back
  // --------------------------------------------------------------------------
  logic                   s1_valid_q;
  s1_t                    s1_q;
  logic                   fwd_valid_q;
  logic [PREFIX_BITS-1:0] fwd_addr_q;
  logic [FREQ_BITS-1:0]   fwd_freq_q;
  logic [COUNT_BITS-1:0]  count_q;

  logic [FREQ_BITS-1:0]   freq_d;
  logic [FREQ_BITS-1:0]   freq_s;
  logic [FREQ_BITS:0]     add;
  logic [COUNT_BITS:0]    count_sum;
  logic [COUNT_BITS-1:0]  count_next;
  logic                   res_push;
  res_t                   s1_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= in_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q <= s0_item;
    end
  end

  // the previous element was written at the edge this one was read, so the
  // memory output misses it; the forward register holds that write
  always_comb begin
    if (fwd_valid_q && (fwd_addr_q == s1_q.d_addr)) begin
      freq_d = fwd_freq_q;
    end else if (rd_d_q.tag == s1_q.epoch) begin
      freq_d = rd_d_q.freq;
    end else begin
      freq_d = '0;
    end
    if (!s1_q.d_ok) begin
      freq_d = '0;
    end

    if (fwd_valid_q && (fwd_addr_q == s1_q.s_addr)) begin
      freq_s = fwd_freq_q;
    end else if (rd_s_q.tag == s1_q.epoch) begin
      freq_s = rd_s_q.freq;
    end else begin
      freq_s = '0;
    end
  end

  assign add        = {1'b0, freq_d} + (FREQ_BITS+1)'(s1_q.eq);
  assign count_sum  = {1'b0, count_q} + (COUNT_BITS+1)'(add);
  assign count_next = count_sum[COUNT_BITS] ? COUNT_MAX : count_sum[COUNT_BITS-1:0];

  assign res_push = s1_valid_q && advance;

  // the closing element needs no write-back, its array is dropped anyway
  assign wr_en         = res_push && !s1_q.skip && !s1_q.last;
  assign wr_addr       = s1_q.s_addr;
  assign wr_word.tag   = s1_q.epoch;
  assign wr_word.freq  = (freq_s == FREQ_MAX) ? FREQ_MAX : freq_s + 1'b1;

  always_comb begin
    s1_res.match_total = s1_q.skip ? count_q : count_next;
    s1_res.done        = s1_q.last;
    s1_res.ovf         = s1_q.ovf;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      fwd_valid_q <= 1'b0;
    end else if (advance) begin
      fwd_valid_q <= wr_en;
      if (res_push) begin
        if (s1_q.last) begin
          count_q <= '0;
        end else if (!s1_q.skip) begin
          count_q <= count_next;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      fwd_addr_q <= wr_addr;
      fwd_freq_q <= wr_word.freq;
    end
  end

  // --------------------------------------------------------------------------
  // output register with skid stage
  // --------------------------------------------------------------------------
  logic out_valid_q;
  res_t out_q;
  res_t skid_q;
  logic out_take;

  assign out_take = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (res_push) begin
      if (out_valid_q && !out_take) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (res_push) begin
      if (out_valid_q && !out_take) begin
        skid_q <= s1_res;
      end else begin
        out_q <= s1_res;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign match_total_o     = out_q.match_total;
  assign array_done_o      = out_q.done;
  assign length_overflow_o = out_q.ovf;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_no_write_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(sweep_active_q && wr_en))
    else $error("item write-back during clearing sweep");

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds a result while output register is empty");

  a_epoch_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    epoch_q != '0)
    else $error("array tag collides with swept tag");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && is_last_i) |=> (elements_q == '0 && prefix_q == '0))
    else $error("array state not cleared after last element");

  a_sweep_only_closing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && sweep_active_q) |-> s1_q.last)
    else $error("open array element in stage one during clearing sweep");

endmodule

`default_nettype wire

[bench/tb_subarray_sum_match_counter.sv]
// ----------------------------------------------------------------------------
// tb_subarray_sum_match_counter - self-checking bench for the match counter
// streams arrays of signed elements under random sender gaps and receiver
// stalls, predicts every running match total with its own prefix-sum tally
// and checks each result field in order, across several target settings
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_subarray_sum_match_counter;
  import ssmc_pkg::*;

  // cycles with no request or result moving before the run is declared hung;
  // covers the full clearing sweep plus the long receiver hold-off
  localparam int unsigned IDLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 600;
  localparam int unsigned MAX_PRINTS = 20;

  typedef struct {
    logic [ELEMENT_BITS-1:0] value;
    logic                    last;
  } element_item_t;

  typedef struct {
    logic [COUNT_BITS-1:0] match_total;
    logic                  array_done;
    logic                  length_overflow;
  } count_result_t;

  // clock and reset
  logic clk_i;
  logic rst_ni = 1'b0;

  // request channel
  logic                    in_valid      = 1'b0;
  logic                    in_stall;
  logic [ELEMENT_BITS-1:0] element_value = '0;
  logic                    is_last       = 1'b0;

  // result channel
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [COUNT_BITS-1:0] match_total;
  logic                  array_done;
  logic                  length_overflow;

  // register port
  logic                     psel    = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite  = 1'b0;
  logic [APB_ADDR_BITS-1:0] paddr   = '0;
  logic [APB_DATA_BITS-1:0] pwdata  = '0;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;

  // stimulus and expectations
  element_item_t element_queue[$];
  count_result_t pending_counts[$];

  // predictor state, mirrors the block's view of the current array
  int                     target_sum_q      = 0;
  logic [PREFIX_BITS-1:0] prefix_total      = '0;
  int                     running_matches   = 0;
  int                     elements_in_array = 0;
  logic                   length_overflowed = 1'b0;
  int unsigned            freq_by_prefix[bit [PREFIX_BITS-1:0]];

  // bookkeeping
  int error_count     = 0;
  int elements_sent   = 0;
  int results_checked = 0;
  int arrays_closed   = 0;
  int overflow_results = 0;
  int highest_total   = 0;
  int settings_used   = 0;

  // sender burst shaping and receiver stall pattern
  int  burst_left   = 1;
  int  gap_left     = 0;
  int  pattern_left = 0;
  int  stall_pct    = 0;
  int  hold_left    = 0;
  bit  hold_done    = 1'b0;
  int  idle_cycles  = 0;

  subarray_sum_match_counter dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .element_value_i   (element_value),
    .is_last_i         (is_last),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .match_total_o     (match_total),
    .array_done_o      (array_done),
    .length_overflow_o (length_overflow),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // advance the prefix sum by one element and work out the running total;
  // elements beyond the length limit leave the tally alone and only flag it
  function automatic count_result_t tally_element(logic [ELEMENT_BITS-1:0] elem,
                                                  logic last);
    count_result_t          r;
    logic [PREFIX_BITS-1:0] sum;
    int                     e;
    int                     s;
    int                     d;
    int                     add;
    if (elements_in_array >= MAX_LENGTH) begin
      length_overflowed = 1'b1;
    end else begin
      e   = $signed(elem);
      sum = prefix_total + e[PREFIX_BITS-1:0];
      s   = $signed(sum);
      d   = s - target_sum_q;
      add = 0;
      // a difference outside the 16 bit range can never match a stored prefix
      if (d >= -32768 && d <= 32767 && freq_by_prefix.exists(d[PREFIX_BITS-1:0]))
        add = freq_by_prefix[d[PREFIX_BITS-1:0]];
      // the prefix alone matching stands for the empty leading subarray
      if (s == target_sum_q)
        add++;
      running_matches = running_matches + add;
      if (running_matches > COUNT_MAX)
        running_matches = COUNT_MAX;
      if (!freq_by_prefix.exists(sum))
        freq_by_prefix[sum] = 1;
      else if (freq_by_prefix[sum] < FREQ_MAX)
        freq_by_prefix[sum]++;
      prefix_total = sum;
      elements_in_array++;
    end
    r.match_total     = running_matches[COUNT_BITS-1:0];
    r.array_done      = last;
    r.length_overflow = length_overflowed;
    // closing element wipes the whole array state
    if (last) begin
      prefix_total      = '0;
      running_matches   = 0;
      elements_in_array = 0;
      length_overflowed = 1'b0;
      freq_by_prefix.delete();
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    error_count++;
    if (error_count <= MAX_PRINTS)
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // setup cycle, access cycle, then hold until the write edge with pready high
  task automatic write_register(reg_idx_e idx, logic [APB_DATA_BITS-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_BITS'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // only called while idle, so the predictor picks up the new target cleanly
  task automatic set_target(int value);
    write_register(REG_TARGET_SUM, value);
    target_sum_q = value;
    settings_used++;
    // address still points at the target, which reads back sign-extended
    @(posedge clk_i);
    if ($signed(prdata) != value)
      report_mismatch("target_sum readback", prdata, value);
  endtask

  task automatic push_element(int value, bit last);
    element_item_t item;
    item.value = value[ELEMENT_BITS-1:0];
    item.last  = last;
    element_queue.push_back(item);
  endtask

  // mostly small values so that matches are frequent, some full-range noise
  task automatic push_random_array(int len, int full_pct);
    int v;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < full_pct)
        v = $urandom_range(0, (1 << ELEMENT_BITS) - 1);
      else
        v = $urandom_range(0, 6) - 3;
      push_element(v, i == len - 1);
    end
  endtask

  // idle means every queued request sent and every expected result seen
  task automatic wait_drained();
    while (element_queue.size() != 0 || in_valid || pending_counts.size() != 0)
      @(negedge clk_i);
  endtask

  // request driver: bursts of random length separated by random gaps,
  // payload held steady while the block stalls
  always @(posedge clk_i) begin
    element_item_t nxt;
    logic          offer;
    if (rst_ni) begin
      if (in_valid && !in_stall) begin
        pending_counts.push_back(tally_element(element_value, is_last));
        elements_sent++;
      end
      if (!in_valid || !in_stall) begin
        offer = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (element_queue.size() != 0) begin
          nxt   = element_queue.pop_front();
          offer = 1'b1;
          element_value <= nxt.value;
          is_last       <= nxt.last;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 32);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end
        in_valid <= offer;
      end
    end
  end

  // receiver stall: segments of random stall density, and once a long
  // hold-off so the pipeline backs up into the request side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!hold_done && elements_sent >= 400) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (pattern_left == 0) begin
          pattern_left = $urandom_range(8, 80);
          case ($urandom_range(0, 4))
            0, 1: begin
              stall_pct = 0;
            end
            2: begin
              stall_pct = 20;
            end
            3: begin
              stall_pct = 50;
            end
            default: begin
              stall_pct = 80;
            end
          endcase
        end
        pattern_left--;
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // result monitor: oldest expectation against each accepted result
  always @(posedge clk_i) begin
    count_result_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_counts.size() == 0) begin
        report_mismatch("unexpected result, total", match_total, -1);
      end else begin
        want = pending_counts.pop_front();
        results_checked++;
        if (match_total !== want.match_total)
          report_mismatch("match_total", match_total, want.match_total);
        if (array_done !== want.array_done)
          report_mismatch("array_done", array_done, want.array_done);
        if (length_overflow !== want.length_overflow)
          report_mismatch("length_overflow", length_overflow, want.length_overflow);
        if (want.array_done)
          arrays_closed++;
        if (want.length_overflow)
          overflow_results++;
        if (want.match_total > highest_total)
          highest_total = want.match_total;
      end
    end
  end

  // watchdog on cycles where neither channel moves
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: nothing moved for %0d cycles, %0d results outstanding",
                 idle_cycles, pending_counts.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    int target_plan[10];
    int left;
    int len;

    target_plan = '{0, 1, -1, 3, -5, 2, 65535, -65536, 6, -2};
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // the spare register address takes writes but must not disturb anything
    write_register(REG_UNUSED, $urandom());

    // directed arrays at the reset target of zero
    push_element(127, 1);
    push_element(-128, 1);
    // single zero matches through the empty prefix
    push_element(0, 1);
    push_element(1, 0);
    push_element(-1, 1);
    push_element(2, 0);
    push_element(-2, 0);
    push_element(2, 0);
    push_element(-2, 1);
    push_element(-128, 0);
    push_element(127, 0);
    push_element(1, 1);
    push_element(0, 0);
    push_element(0, 0);
    push_element(0, 1);
    wait_drained();

    // extreme targets push the difference outside the prefix range
    set_target(65535);
    push_element(127, 0);
    push_element(-128, 1);
    wait_drained();
    set_target(-65536);
    push_element(-128, 0);
    push_element(127, 1);
    wait_drained();

    // random phases, one target each, arrays mostly short
    for (int p = 0; p < 10; p++) begin
      set_target(target_plan[p]);
      left = 65;
      while (left > 0) begin
        len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 5) : $urandom_range(6, 24);
        if (len > left)
          len = left;
        push_random_array(len, 20);
        left -= len;
      end
      wait_drained();
    end

    // most negative prefix reached exactly at the length limit, then requests past
    // the limit, including the closing one, leave the total alone and flag overflow
    set_target(-32768);
    for (int i = 0; i < MAX_LENGTH + 4; i++)
      push_element(-128, i == MAX_LENGTH + 3);
    wait_drained();

    // long random array running over the limit at a small random target
    set_target($urandom_range(0, 8) - 4);
    push_random_array(MAX_LENGTH + 2, 20);
    push_random_array(7, 20);
    wait_drained();

    // let any stray late result show up
    repeat (20) @(posedge clk_i);
    if (pending_counts.size() != 0)
      report_mismatch("results never delivered", 0, pending_counts.size());

    $display("covered %0d elements in %0d closed arrays over %0d target settings",
             elements_sent, arrays_closed, settings_used);
    $display("%0d results checked, %0d flagged length overflow, peak match total %0d",
             results_checked, overflow_results, highest_total);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
